// ===== rtl/bb3x3_pkg.sv =====
// Shared types and constants of the 3x3 RGB box blur core.
package bb3x3_pkg;

	// Default build sizes.
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int CHANNEL_BITS_DEF = 8;

	// Configuration register file.
	localparam int FW_BITS         = 11;
	localparam int FH_BITS         = 13;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 13;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
	localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

	// Frame geometry limits.
	localparam int HEIGHT_LIMIT = 4096;
	localparam int IN_ROW_BITS  = 13;
	localparam int OUT_ROW_BITS = 12;
	localparam logic [IN_ROW_BITS-1:0] IN_ROW_LIMIT = 13'd8191;

	// Input item kind carried on tuser.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Per-item decisions made when the item enters the pipeline.
	typedef struct packed {
		logic emit;      // the item releases one output pixel
		logic interior;  // that pixel is averaged rather than passed through
		logic last;      // that pixel closes the frame
	} pos_flags_t;

endpackage

// ===== rtl/bb3x3_pos_ctrl.sv =====
// Input and output position counters of the 3x3 box blur.
module bb3x3_pos_ctrl #(
	parameter int MAX_WIDTH = bb3x3_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [bb3x3_pkg::FW_BITS-1:0]    frame_width,
	input  logic [bb3x3_pkg::FH_BITS-1:0]    frame_height,
	output logic [$clog2(MAX_WIDTH)-1:0]     col,
	output bb3x3_pkg::pos_flags_t            flags
);
	import bb3x3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [AW-1:0]           in_col_q;
	logic [IN_ROW_BITS-1:0]  in_row_q;
	logic [AW-1:0]           out_col_q;
	logic [OUT_ROW_BITS-1:0] out_row_q;

	logic [WW-1:0]      w_eff;
	logic [FH_BITS-1:0] h_eff;
	logic               in_wrap;
	logic               out_col_end;
	logic               out_row_end;

	// Out-of-range sizes are clamped to the nearest legal value.
	always_comb begin
		if (frame_width == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width);
		end
		if (frame_height == '0) begin
			h_eff = FH_BITS'(1);
		end else if (32'(frame_height) > 32'(HEIGHT_LIMIT)) begin
			h_eff = FH_BITS'(HEIGHT_LIMIT);
		end else begin
			h_eff = frame_height;
		end
	end

	always_comb begin
		in_wrap     = (32'(in_col_q) + 32'd1) >= 32'(w_eff);
		out_col_end = (32'(out_col_q) + 32'd1) >= 32'(w_eff);
		out_row_end = (32'(out_row_q) + 32'd1) >= 32'(h_eff);

		flags.emit     = (in_row_q >= IN_ROW_BITS'(2)) ||
		                 ((in_row_q == IN_ROW_BITS'(1)) && (in_col_q != '0));
		flags.last     = out_col_end && out_row_end;
		flags.interior = (out_col_q != '0) && (out_row_q != '0) &&
		                 !out_col_end && !out_row_end;
	end

	assign col = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (flags.emit && flags.last) begin
				// The frame is complete: the next item starts a new one.
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != IN_ROW_LIMIT) begin
						in_row_q <= in_row_q + IN_ROW_BITS'(1);
					end
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (flags.emit) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OUT_ROW_BITS'(1);
					end else begin
						out_col_q <= out_col_q + AW'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/bb3x3_line_store.sv =====
// Two-row line store: one memory word per column holding the two rows above.
module bb3x3_line_store #(
	parameter int MAX_WIDTH = bb3x3_pkg::MAX_WIDTH_DEF,
	parameter int PIX_BITS  = 3 * bb3x3_pkg::CHANNEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [2*PIX_BITS-1:0]        rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [2*PIX_BITS-1:0]        wr_data
);
	import bb3x3_pkg::*;

	localparam int EW = 2 * PIX_BITS;

	logic [EW-1:0] mem [MAX_WIDTH];
	logic [EW-1:0] mem_q;
	logic [EW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read that meets a write to the same word in the same cycle sees the
	// old word from the array, so the new word is bypassed instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_q;

endmodule

// ===== rtl/bb3x3_window.sv =====
// 3x3 window registers, channel sums and the divide-by-nine stage.
module bb3x3_window #(
	parameter int CHANNEL_BITS = bb3x3_pkg::CHANNEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        valid_s1,
	input  bb3x3_pkg::pos_flags_t       flags_s1,
	input  logic [3*CHANNEL_BITS-1:0]   top,
	input  logic [3*CHANNEL_BITS-1:0]   mid,
	input  logic [3*CHANNEL_BITS-1:0]   pix,
	output logic                        res_valid,
	output logic [3*CHANNEL_BITS-1:0]   res_pix,
	output logic                        res_last
);
	import bb3x3_pkg::*;

	localparam int CB  = CHANNEL_BITS;
	localparam int PW  = 3 * CB;
	localparam int SB  = CB + 4;
	localparam int K   = SB + 4;
	localparam int MW  = K - 2;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd8) / 64'd9);

	logic [PW-1:0] win_q [9];

	logic          valid_s2;
	logic          interior_s2;
	logic          last_s2;

	logic          valid_s3;
	logic          interior_s3;
	logic          last_s3;
	logic [PW-1:0] center_s3;
	logic [SB-1:0] sum_s3 [3];

	logic [SB-1:0]    sum_s2 [3];
	logic [SB+MW-1:0] prod [3];
	logic [PW-1:0]    mean_pix;

	// Window index is column * 3 + row, column 0 oldest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv && valid_s1) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= win_q[i + 3];
			end
			win_q[6] <= top;
			win_q[7] <= mid;
			win_q[8] <= pix;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_s2[ch] = ((SB'(win_q[0][ch*CB +: CB]) + SB'(win_q[1][ch*CB +: CB])) +
			              (SB'(win_q[2][ch*CB +: CB]) + SB'(win_q[3][ch*CB +: CB]))) +
			             ((SB'(win_q[4][ch*CB +: CB]) + SB'(win_q[5][ch*CB +: CB])) +
			              (SB'(win_q[6][ch*CB +: CB]) + SB'(win_q[7][ch*CB +: CB])) +
			              SB'(win_q[8][ch*CB +: CB]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && flags_s1.emit;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			interior_s2 <= flags_s1.interior;
			last_s2     <= flags_s1.last;
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;
			center_s3   <= win_q[4];
			for (int ch = 0; ch < 3; ch++) begin
				sum_s3[ch] <= sum_s2[ch];
			end
		end
	end

	// Exact floor(sum / 9) by a rounded-up reciprocal wide enough for the
	// full range of a nine-term sum.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = (SB+MW)'(sum_s3[ch]) * (SB+MW)'(RECIP);
			mean_pix[ch*CB +: CB] = prod[ch][K +: CB];
		end
	end

	assign res_valid = valid_s3;
	assign res_pix   = interior_s3 ? mean_pix : center_s3;
	assign res_last  = last_s3;

endmodule

// ===== rtl/bb3x3_out_buf.sv =====
// Output register with a skid stage so the pipeline stalls only on a full skid.
module bb3x3_out_buf #(
	parameter int DATA_BITS = 3 * bb3x3_pkg::CHANNEL_BITS_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DATA_BITS-1:0] in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_BITS-1:0] out_data
);
	import bb3x3_pkg::*;

	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_data_q;
	logic                 skid_valid_q;
	logic [DATA_BITS-1:0] skid_data_q;
	logic                 push;
	logic                 take;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && !skid_valid_q;
	assign take     = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (out_valid_q && !out_ready) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end else if (take && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/box_blur_3x3_rgb_core.sv =====
// A pixel passes stage 1, window, sums and output register; results lag by width+1 items.
// Throughput: one request per cycle, using the separate read and write ports of the line store.
// A full skid stage holds off new requests until the output side takes a result.
// Reset clears counters, window, pipeline and output valids and loads width 640, height 480.
// The line store is not cleared; each entry is written before an interior pixel can read it.
module box_blur_3x3_rgb_core #(
	parameter int MAX_WIDTH    = bb3x3_pkg::MAX_WIDTH_DEF,
	parameter int CHANNEL_BITS = bb3x3_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Configuration writes.
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [bb3x3_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [bb3x3_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	// Pixel stream in.
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      s_tdata,  // red_in, green_in, blue_in
	input  logic                                     s_tuser,  // kind
	// Blurred stream out.
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      m_tdata,  // red_out, green_out, blue_out
	output logic                                     m_tlast   // frame_end
);
	import bb3x3_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int PW  = 3 * CHANNEL_BITS;
	localparam int TDW = ((PW + 7) / 8) * 8;

	// Configuration registers. Writes are only expected while the core is
	// idle, so the port is always ready.
	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves in lock step and only halts when the skid
	// stage in front of the output already holds a result.
	logic adv;
	logic accept;

	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// Entry stage: the counters decide, from the position of this request,
	// whether it releases an output and how that output is formed. The
	// line store read for its column is issued in the same cycle.
	logic [AW-1:0] col;
	pos_flags_t    flags;
	logic [PW-1:0] pix_in;

	bb3x3_pos_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.col          (col),
		.flags        (flags)
	);

	// A flush request enters the rows as black.
	assign pix_in = (s_tuser == KIND_FLUSH) ? '0 : s_tdata[PW-1:0];

	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [PW-1:0] pix_s1;
	pos_flags_t    flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= col;
			pix_s1   <= pix_in;
			flags_s1 <= flags;
		end
	end

	// Stage 1: the column word comes back as {two rows above, row above}.
	// It is written back shifted by one row with the new pixel below it.
	// Back-to-back requests to the same column (a one-pixel-wide frame)
	// are bypassed inside the line store.
	logic [2*PW-1:0] ls_rd_data;
	logic [PW-1:0]   top;
	logic [PW-1:0]   mid;
	logic            ls_wr_en;

	assign top      = ls_rd_data[2*PW-1:PW];
	assign mid      = ls_rd_data[PW-1:0];
	assign ls_wr_en = adv && valid_s1;

	bb3x3_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIX_BITS  (PW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (ls_rd_data),
		.wr_en   (ls_wr_en),
		.wr_addr (addr_s1),
		.wr_data ({mid, pix_s1})
	);

	// Stages 2 and 3: the window takes the new column, then the nine-pixel
	// sums are registered and divided by nine. Border pixels keep the
	// window center unchanged.
	logic          res_valid;
	logic [PW-1:0] res_pix;
	logic          res_last;

	bb3x3_window #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.flags_s1  (flags_s1),
		.top       (top),
		.mid       (mid),
		.pix       (pix_s1),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	// Output register plus skid stage.
	logic [PW:0] out_data;

	bb3x3_out_buf #(
		.DATA_BITS(PW + 1)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (adv),
		.in_data   ({res_last, res_pix}),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = TDW'(out_data[PW-1:0]);
	assign m_tlast = out_data[PW];

endmodule

// ===== bench/tb_box_blur_3x3_rgb_core.sv =====
// Self-checking testbench for the 3x3 RGB box blur core.
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_core;
	import bb3x3_pkg::*;

	localparam int MAX_W = MAX_WIDTH_DEF;
	// Cycles with no request accepted on any channel before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Cycles allowed for the pipeline to settle once every expected pixel has arrived.
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum {STYLE_RANDOM, STYLE_EXTREME, STYLE_FULL, STYLE_ZERO} px_style_t;

	typedef struct packed {
		logic       frame_end;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} blur_px_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [23:0]               s_tdata = '0;   // red_in, green_in, blue_in
	logic                      s_tuser = KIND_PIXEL;   // kind
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [23:0]               m_tdata;        // red_out, green_out, blue_out
	logic                      m_tlast;        // frame_end

	box_blur_3x3_rgb_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// Predictor state: register copies, two line stores, window and position counters.
	logic [FW_BITS-1:0] width_reg = FRAME_WIDTH_RESET;
	logic [FH_BITS-1:0] height_reg = FRAME_HEIGHT_RESET;
	logic [23:0]        line_mem [2*MAX_W];
	logic [23:0]        win [9];
	int unsigned        in_col = 0;
	int unsigned        in_row_n = 0;
	int unsigned        out_col = 0;
	int unsigned        out_row_n = 0;

	blur_px_t    pending_px[$];
	int unsigned fail_count = 0;
	int unsigned reqs_sent = 0;
	int unsigned flush_sent = 0;
	int unsigned px_checked = 0;
	int unsigned interior_px = 0;
	int unsigned frames_sent = 0;
	int unsigned max_w_seen = 0;
	int unsigned max_h_seen = 0;
	int unsigned hold_off_cycles = 0;
	bit          steady_flow = 1'b0;

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	// Advances the predictor by one accepted request and queues the pixel it releases.
	function automatic void predict_blur(input logic kind, input logic [23:0] rgb);
		int unsigned w, h, col, sum, ch, k;
		logic [23:0] pix, above, above2;
		logic [7:0]  chan [3];
		bit          emit;
		blur_px_t    px;
		w = eff_width();
		h = eff_height();
		// A flush request loads black into the line stores.
		pix = (kind == KIND_PIXEL) ? rgb : 24'h0;
		col = (in_col >= MAX_W) ? 0 : in_col;
		above2 = line_mem[MAX_W + col];
		above = line_mem[col];
		line_mem[MAX_W + col] = above;
		line_mem[col] = pix;
		for (k = 0; k < 6; k++) win[k] = win[k + 3];
		win[6] = above2;
		win[7] = above;
		win[8] = pix;
		emit = (in_row_n >= 2) || (in_row_n == 1 && in_col >= 1);
		if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row_n < IN_ROW_LIMIT) in_row_n++;
		end else begin
			in_col++;
		end
		if (!emit) return;
		if (out_col >= 1 && out_row_n >= 1 && out_col + 1 < w && out_row_n + 1 < h) begin
			interior_px++;
			for (ch = 0; ch < 3; ch++) begin
				sum = 0;
				for (k = 0; k < 9; k++) sum += win[k][ch*8 +: 8];
				chan[ch] = 8'(sum / 9);
			end
		end else begin
			// Border pixels leave untouched.
			for (ch = 0; ch < 3; ch++) chan[ch] = win[4][ch*8 +: 8];
		end
		px.red = chan[0];
		px.green = chan[1];
		px.blue = chan[2];
		px.frame_end = (out_col + 1 >= w) && (out_row_n + 1 >= h);
		pending_px.push_back(px);
		if (px.frame_end) begin
			in_col = 0;
			in_row_n = 0;
			out_col = 0;
			out_row_n = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row_n = (out_row_n + 1) & 12'hFFF;
		end else begin
			out_col++;
		end
	endfunction

	function automatic logic [23:0] make_rgb(input px_style_t style);
		case (style)
			STYLE_EXTREME: return {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
				{8{1'($urandom_range(1))}}};
			STYLE_FULL:    return 24'hFFFFFF;
			STYLE_ZERO:    return 24'h000000;
			default:       return 24'($urandom);
		endcase
	endfunction

	// Output side: checks every accepted pixel, then picks tready for the next cycle.
	// A requested hold-off is counted down here, independent of the sender.
	always @(posedge clk) begin : out_side
		blur_px_t want;
		if (m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				$error("output pixel 0x%06h with no request pending", m_tdata);
				fail_count++;
			end else begin
				want = pending_px.pop_front();
				if (m_tdata[7:0] !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[15:8] !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, m_tdata[15:8]);
					fail_count++;
				end
				if (m_tdata[23:16] !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, m_tdata[23:16]);
					fail_count++;
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end, m_tlast);
					fail_count++;
				end
				px_checked++;
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady_flow || ($urandom_range(99) >= 26);
		end
	end

	// Watchdog: the run is abandoned when no channel accepts a request for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("box_blur_3x3_rgb_core test failed");
		$finish;
	end

	// Sends one request, with random idle cycles ahead of it, and leaves tvalid high.
	task automatic send_req(input logic kind, input logic [23:0] rgb);
		while (!steady_flow && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= rgb;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_blur(kind, rgb);
		reqs_sent++;
		if (kind == KIND_FLUSH) flush_sent++;
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_px.size() != 0) @(posedge clk);
	endtask

	// The block is idle once every expected pixel has left and the pipeline has settled.
	task automatic wait_idle();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg = value[FW_BITS-1:0];
			REG_FRAME_HEIGHT: height_reg = value;
			default: ;
		endcase
	endtask

	task automatic set_size(input logic [CFG_DATA_BITS-1:0] w_data,
			input logic [CFG_DATA_BITS-1:0] h_data);
		write_reg(REG_FRAME_WIDTH, w_data);
		write_reg(REG_FRAME_HEIGHT, h_data);
	endtask

	// One whole frame plus its width+1 flush requests. With noise, the kind of some
	// requests is flipped: flush inside the frame, pixels during the flush phase.
	task automatic send_frame(input px_style_t style, input int noise_pct,
			input bit pause_mid);
		int unsigned w, h, n_pix, i;
		logic kind;
		w = eff_width();
		h = eff_height();
		n_pix = w * h;
		if (w > max_w_seen) max_w_seen = w;
		if (h > max_h_seen) max_h_seen = h;
		for (i = 0; i < n_pix + w + 1; i++) begin
			if (pause_mid && i == n_pix / 2) pause_until_drained();
			kind = (i < n_pix) ? KIND_PIXEL : KIND_FLUSH;
			if ($urandom_range(99) < noise_pct) kind = ~kind;
			send_req(kind, make_rgb(style));
		end
		frames_sent++;
	endtask

	// Smallest frame with an interior pixel: first at full scale for the largest sum,
	// then a checker with a flush inside the frame and a pixel during the flush phase.
	// Finally zero sizes, which act as a single-pixel frame.
	task automatic test_directed();
		int i;
		set_size(3, 3);
		for (i = 0; i < 13; i++)
			send_req((i < 9) ? KIND_PIXEL : KIND_FLUSH, (i < 9) ? 24'hFFFFFF : make_rgb(STYLE_RANDOM));
		for (i = 0; i < 13; i++) begin
			if (i == 3)
				send_req(KIND_FLUSH, 24'hFFFFFF);
			else if (i == 10)
				send_req(KIND_PIXEL, make_rgb(STYLE_RANDOM));
			else if (i < 9)
				send_req(KIND_PIXEL, (i % 2) ? 24'h00FF00 : 24'hFF00FF);
			else
				send_req(KIND_FLUSH, 24'h5AA55A);
		end
		frames_sent += 2;
		set_size(0, 0);
		send_req(KIND_PIXEL, 24'hA53CC3);
		send_req(KIND_FLUSH, 24'h000000);
		send_req(KIND_FLUSH, 24'hFFFFFF);
		frames_sent++;
	endtask

	// Mostly well-formed frames of random small sizes with random content; some frames
	// follow each other with no gap and no size change.
	task automatic test_random_frames();
		int unsigned start, w, h, pick;
		px_style_t style;
		start = reqs_sent;
		while (reqs_sent - start < 480) begin
			if ($urandom_range(99) < 70) begin
				w = ($urandom_range(99) < 5) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				h = $urandom_range(1, 8);
				if ($urandom_range(99) < 4) w = 0;
				if ($urandom_range(99) < 4) h = 0;
				// The upper data bits are ignored by the width register.
				set_size({2'($urandom_range(3)), 11'(w)}, 13'(h));
			end
			pick = $urandom_range(99);
			style = (pick < 80) ? STYLE_RANDOM : (pick < 90) ? STYLE_EXTREME :
				(pick < 95) ? STYLE_FULL : STYLE_ZERO;
			send_frame(style, 5, 1'b0);
		end
	endtask

	// Back-to-back frames at full rate with neither side idling.
	task automatic test_steady_stream();
		set_size(20, 6);
		steady_flow = 1'b1;
		repeat (3) send_frame(STYLE_RANDOM, 0, 1'b0);
		steady_flow = 1'b0;
	endtask

	// The receiver stops for a long stretch so the block fills and refuses requests.
	task automatic test_output_backpressure();
		set_size(16, 10);
		hold_off_cycles = HOLD_OFF_CYCLES;
		send_frame(STYLE_RANDOM, 0, 1'b0);
	endtask

	// The sender stops in mid frame until every pending pixel has arrived.
	task automatic test_sender_pause();
		set_size(9, 7);
		send_frame(STYLE_RANDOM, 3, 1'b1);
	endtask

	// A zero register value acts as one pixel per row or as one row per frame.
	task automatic test_size_limits();
		set_size(0, 4);
		send_frame(STYLE_RANDOM, 0, 1'b0);
		set_size(6, 0);
		send_frame(STYLE_EXTREME, 0, 1'b0);
	endtask

	initial begin : main_seq
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win[i]) win[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames();
		test_steady_stream();
		test_output_backpressure();
		test_sender_pause();
		test_size_limits();
		wait_idle();
		$display("Covered %0d frames up to %0d wide and %0d tall: %0d requests, %0d of them flush.",
			frames_sent, max_w_seen, max_h_seen, reqs_sent, flush_sent);
		$display("Checked %0d output pixels, %0d averaged and the rest passed through.",
			px_checked, interior_px);
		if (fail_count == 0 && pending_px.size() == 0)
			$display("box_blur_3x3_rgb_core test passed");
		else
			$display("box_blur_3x3_rgb_core test failed");
		$finish;
	end

endmodule
